@@ src/tkk_pkg.sv @@
// Package for the top-k keeper: field widths, mode and kind codes,
// configuration register indexes and the scan request struct.
// No dependencies.
`default_nettype none
package tkk_pkg;

  // Default store size (number of values that can be kept)
  localparam int MAX_KEEP_DEF = 16;

  // Field widths
  localparam int VALUE_W = 64;
  localparam int MODE_W  = 2;
  localparam int KIND_W  = 2;
  localparam int BCNT_W  = 16;
  localparam int KCNT_W  = 5;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 5;
  // Compare domain for fill against keep count (holds MAX_KEEP + 1 up to 63)
  localparam int CNT_W = 6;

  // Input modes
  localparam logic [MODE_W-1:0] MODE_DATA   = 2'd0;
  localparam logic [MODE_W-1:0] MODE_MARKER = 2'd1;
  localparam logic [MODE_W-1:0] MODE_SETCNT = 2'd2;

  // Result kinds
  localparam logic [KIND_W-1:0] KIND_CREDIT = 2'd0;
  localparam logic [KIND_W-1:0] KIND_VALUE  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_EOS    = 2'd2;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_KEEP_COUNT   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_KEEP_LARGEST = 2'd1;

  // Read data arriving at the compare unit during a worst-value scan
  typedef struct packed {
    logic vld;           // read data valid this cycle
    logic first;         // entry 0: seeds the running worst
    logic keep_largest;  // direction: 1 means smaller is worse
  } scan_req_t;

endpackage
`default_nettype wire

@@ src/top_k_keeper_with_eos_flush.sv @@
// Top level of the top-k keeper: sequencer, counters, config and output register.
// Uses tkk_store and tkk_scan; needs tkk_pkg.
// Data is written, then checked for eviction; each eviction scans every stored entry.
//   A marker gives a credit result; a flush scans before each removal, then ends with EOS.
// One request at a time (in_ready only when idle); result stalls add cycles.
// Sync active-low reset resets control, counters and config to defaults; store not cleared.
`default_nettype none
module top_k_keeper_with_eos_flush
  import tkk_pkg::*;
#(
  parameter int MAX_KEEP = MAX_KEEP_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  // input channel
  input  wire logic                        in_valid,
  output logic                             in_ready,
  input  wire logic [MODE_W-1:0]           in_mode,
  input  wire logic signed [VALUE_W-1:0]   in_value,
  input  wire logic [BCNT_W-1:0]           in_branch_count,
  // result channel
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output logic [KIND_W-1:0]                out_kind,
  output logic signed [VALUE_W-1:0]        out_result_value,
  output logic                             out_last,
  // configuration channel
  input  wire logic                        cfg_valid,
  output logic                             cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]        cfg_index,
  input  wire logic [CFG_DATA_W-1:0]       cfg_data
);

  localparam int AW = $clog2(MAX_KEEP+1);
  localparam int FW = $clog2(MAX_KEEP+2);

  // Sequencer states
  localparam logic [3:0] ST_IDLE   = 4'd0;
  localparam logic [3:0] ST_EVCHK  = 4'd1;
  localparam logic [3:0] ST_CREDIT = 4'd2;
  localparam logic [3:0] ST_FSTART = 4'd3;
  localparam logic [3:0] ST_SCAN   = 4'd4;
  localparam logic [3:0] ST_EMIT   = 4'd5;
  localparam logic [3:0] ST_RDL    = 4'd6;
  localparam logic [3:0] ST_MOVE   = 4'd7;
  localparam logic [3:0] ST_EOS    = 4'd8;

  logic [3:0]        state_r, state_nxt;
  logic [FW-1:0]     fill_r, fill_nxt;
  logic [FW-1:0]     scan_idx_r, scan_idx_nxt;
  logic              flush_r, flush_nxt;
  logic              due_r, due_nxt;
  logic [BCNT_W-1:0] mrecv_r, mrecv_nxt;
  logic [BCNT_W-1:0] mexp_r, mexp_nxt;
  logic              known_r, known_nxt;
  logic [KCNT_W-1:0] keep_count_r;
  logic              keep_largest_r;

  // read pipeline tracking
  logic              dv_r;
  logic [AW-1:0]     didx_r;
  logic              issue;

  // output register
  logic                      ov_r, ov_nxt;
  logic [KIND_W-1:0]         okind_r, okind_nxt;
  logic signed [VALUE_W-1:0] oval_r, oval_nxt;
  logic                      olast_r, olast_nxt;

  // store and compare unit wiring
  logic                      st_we;
  logic [AW-1:0]             st_waddr;
  logic signed [VALUE_W-1:0] st_wdata;
  logic [AW-1:0]             st_raddr;
  logic signed [VALUE_W-1:0] st_rdata;
  scan_req_t                 sreq;
  logic signed [VALUE_W-1:0] worst_value;
  logic [AW-1:0]             worst_idx;

  logic              in_acc;
  logic              out_free;
  logic [CNT_W-1:0]  kc6, k6, fill6, fill_m1_6;
  logic [FW-1:0]     fill_m1;
  logic [BCNT_W-1:0] mrecv_inc;

  assign in_ready  = (state_r == ST_IDLE);
  assign in_acc    = in_valid && in_ready;
  assign cfg_ready = 1'b1;
  assign out_free  = !ov_r || out_ready;

  // effective keep count, clipped to the store size
  assign kc6       = CNT_W'(keep_count_r);
  assign k6        = (kc6 > CNT_W'(MAX_KEEP)) ? CNT_W'(MAX_KEEP) : kc6;
  assign fill6     = CNT_W'(fill_r);
  assign fill_m1   = fill_r - FW'(1);
  assign fill_m1_6 = CNT_W'(fill_m1);
  assign mrecv_inc = mrecv_r + BCNT_W'(1);

  assign issue = (state_r == ST_SCAN) && (scan_idx_r < fill_r);

  // Sequencer
  always_comb begin
    state_nxt    = state_r;
    fill_nxt     = fill_r;
    scan_idx_nxt = '0;
    flush_nxt    = flush_r;
    due_nxt      = due_r;
    mrecv_nxt    = mrecv_r;
    mexp_nxt     = mexp_r;
    known_nxt    = known_r;
    ov_nxt       = ov_r && !out_ready;
    okind_nxt    = okind_r;
    oval_nxt     = oval_r;
    olast_nxt    = olast_r;
    st_we        = 1'b0;
    st_waddr     = fill_r[AW-1:0];
    st_wdata     = in_value;
    st_raddr     = fill_m1[AW-1:0];
    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          case (in_mode)
            MODE_DATA: begin
              st_we     = 1'b1;
              fill_nxt  = fill_r + FW'(1);
              flush_nxt = 1'b0;
              state_nxt = ST_EVCHK;
            end
            MODE_MARKER: begin
              mrecv_nxt = mrecv_inc;
              due_nxt   = known_r && (mrecv_inc == mexp_r);
              flush_nxt = 1'b1;
              state_nxt = ST_CREDIT;
            end
            MODE_SETCNT: begin
              mexp_nxt  = in_branch_count;
              known_nxt = 1'b1;
              flush_nxt = 1'b1;
              if (mrecv_r == in_branch_count) begin
                state_nxt = ST_FSTART;
              end
            end
            default: begin
            end
          endcase
        end
      end
      ST_EVCHK: begin
        state_nxt = (fill6 > k6) ? ST_SCAN : ST_IDLE;
      end
      ST_CREDIT: begin
        if (out_free) begin
          ov_nxt    = 1'b1;
          okind_nxt = KIND_CREDIT;
          oval_nxt  = '0;
          olast_nxt = !due_r;
          state_nxt = due_r ? ST_FSTART : ST_IDLE;
        end
      end
      ST_FSTART: begin
        state_nxt = (fill_r != '0) ? ST_SCAN : ST_EOS;
      end
      ST_SCAN: begin
        st_raddr = scan_idx_r[AW-1:0];
        if (issue) begin
          scan_idx_nxt = scan_idx_r + FW'(1);
        end else begin
          scan_idx_nxt = scan_idx_r;
          if (!dv_r) begin
            state_nxt = flush_r ? ST_EMIT : ST_RDL;
          end
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          ov_nxt    = 1'b1;
          okind_nxt = KIND_VALUE;
          oval_nxt  = worst_value;
          olast_nxt = 1'b0;
          state_nxt = ST_MOVE;
        end
      end
      ST_RDL: begin
        state_nxt = ST_MOVE;
      end
      ST_MOVE: begin
        // last entry moves into the hole left by the worst one
        st_we    = 1'b1;
        st_waddr = worst_idx;
        st_wdata = st_rdata;
        fill_nxt = fill_m1;
        if (flush_r) begin
          state_nxt = (fill_m1 != '0) ? ST_SCAN : ST_EOS;
        end else begin
          state_nxt = (fill_m1_6 > k6) ? ST_SCAN : ST_IDLE;
        end
      end
      ST_EOS: begin
        if (out_free) begin
          ov_nxt    = 1'b1;
          okind_nxt = KIND_EOS;
          oval_nxt  = '0;
          olast_nxt = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      fill_r     <= '0;
      scan_idx_r <= '0;
      flush_r    <= 1'b0;
      due_r      <= 1'b0;
      mrecv_r    <= '0;
      mexp_r     <= '0;
      known_r    <= 1'b0;
      ov_r       <= 1'b0;
      dv_r       <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      fill_r     <= fill_nxt;
      scan_idx_r <= scan_idx_nxt;
      flush_r    <= flush_nxt;
      due_r      <= due_nxt;
      mrecv_r    <= mrecv_nxt;
      mexp_r     <= mexp_nxt;
      known_r    <= known_nxt;
      ov_r       <= ov_nxt;
      dv_r       <= issue;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    okind_r <= okind_nxt;
    oval_r  <= oval_nxt;
    olast_r <= olast_nxt;
    didx_r  <= scan_idx_r[AW-1:0];
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      keep_count_r   <= KCNT_W'(16);
      keep_largest_r <= 1'b1;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_KEEP_COUNT:   keep_count_r   <= cfg_data[KCNT_W-1:0];
        CFG_KEEP_LARGEST: keep_largest_r <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  // Scan request to the compare unit
  always_comb begin
    sreq.vld          = dv_r;
    sreq.first        = (didx_r == '0);
    sreq.keep_largest = keep_largest_r;
  end

  tkk_store #(
    .MAX_KEEP(MAX_KEEP)
  ) u_store (
    .clk   (clk),
    .we    (st_we),
    .waddr (st_waddr),
    .wdata (st_wdata),
    .raddr (st_raddr),
    .rdata (st_rdata)
  );

  tkk_scan #(
    .MAX_KEEP(MAX_KEEP)
  ) u_scan (
    .clk         (clk),
    .req         (sreq),
    .idx         (didx_r),
    .data        (st_rdata),
    .worst_value (worst_value),
    .worst_idx   (worst_idx)
  );

  assign out_valid        = ov_r;
  assign out_kind         = okind_r;
  assign out_result_value = oval_r;
  assign out_last         = olast_r;

endmodule
`default_nettype wire

@@ src/tkk_store.sv @@
// Value store of the top-k keeper: one write port, one registered read port.
// Depends on tkk_pkg.
`default_nettype none
module tkk_store
  import tkk_pkg::*;
#(
  parameter int MAX_KEEP = MAX_KEEP_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              we,
  input  wire logic [$clog2(MAX_KEEP+1)-1:0]     waddr,
  input  wire logic signed [VALUE_W-1:0]         wdata,
  input  wire logic [$clog2(MAX_KEEP+1)-1:0]     raddr,
  output logic signed [VALUE_W-1:0]              rdata
);

  localparam int DEPTH = MAX_KEEP + 1;

  logic signed [VALUE_W-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port, read every cycle
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

@@ src/tkk_scan.sv @@
// Shared compare unit: tracks the worst value and its index over a scan.
// Depends on tkk_pkg.
`default_nettype none
module tkk_scan
  import tkk_pkg::*;
#(
  parameter int MAX_KEEP = MAX_KEEP_DEF
) (
  input  wire logic                              clk,
  input  wire scan_req_t                         req,
  input  wire logic [$clog2(MAX_KEEP+1)-1:0]     idx,
  input  wire logic signed [VALUE_W-1:0]         data,
  output logic signed [VALUE_W-1:0]              worst_value,
  output logic [$clog2(MAX_KEEP+1)-1:0]          worst_idx
);

  localparam int AW = $clog2(MAX_KEEP+1);

  logic signed [VALUE_W-1:0] worst_r;
  logic [AW-1:0]             worst_idx_r;
  logic                      is_worse;

  // data worse than running worst under the current direction
  always_comb begin
    if (req.keep_largest) begin
      is_worse = data < worst_r;
    end else begin
      is_worse = data > worst_r;
    end
  end

  always_ff @(posedge clk) begin
    if (req.vld && (req.first || is_worse)) begin
      worst_r     <= data;
      worst_idx_r <= idx;
    end
  end

  assign worst_value = worst_r;
  assign worst_idx   = worst_idx_r;

endmodule
`default_nettype wire
